@@ hdl/swm_pkg.sv @@
`default_nettype none

package swm_pkg;

    // Width of the window length register as seen on the configuration port.
    localparam int CFG_W = 9;

    // Entries in the request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_DOM_RD,
        S_DOM_CHK,
        S_PUSH,
        S_RES_RD,
        S_RES
    } t_state;

endpackage

`default_nettype wire

@@ hdl/sliding_window_max_top.sv @@
// Running maximum over the latest window_length signed samples.
//
// Input request (s-side): tdata carries sample_value, tuser carries
// first_sample, which restarts the stream with this sample. A result (m-side)
// is given for each sample once window_length samples have arrived since the
// stream start; earlier samples give none. The config channel writes
// window_length (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW).
//
// A four-entry queue takes requests while the back end works. The back end
// keeps a monotonic candidate store in a single-port memory and handles one
// sample at a time, paced by the one read port of that memory; every dropped
// candidate costs an extra read. After the store update, S_RES_RD and S_RES
// pass before the output register loads and m_tvalid rises, later while the
// output register still holds an earlier result.
//
// Reset empties the store and queue and sets window_length to 1. No clearing
// pass is needed. When the receiver stalls, the output register holds the
// result; the back end waits with the next one and the queue fills before
// s_tready drops.
`default_nettype none

module sliding_window_max_top #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_WIDTH-1:0] sample_value, upper bits zero padding
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // [0] first_sample
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [SAMPLE_WIDTH-1:0] window_max, upper bits zero padding
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic                    q_valid;
    logic                    q_pop;
    logic [SAMPLE_WIDTH-1:0] q_value;
    logic                    q_first;
    logic [CW-1:0]           len;
    logic [SAMPLE_WIDTH-1:0] out_value;

    swm_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_value     (s_tdata[SAMPLE_WIDTH-1:0]),
        .i_first     (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_value   (q_value),
        .o_q_first   (q_first),
        .o_len       (len)
    );

    swm_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_value (q_value),
        .i_q_first (q_first),
        .i_len     (len),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_value   (out_value)
    );

    assign m_tdata = DW'(out_value);

endmodule

`default_nettype wire

@@ hdl/swm_front.sv @@
`default_nettype none

module swm_front #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32,
    parameter int CW           = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input request
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]       i_value,
    input  wire logic                          i_first,
    // configuration write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]     i_cfg_data,
    // queue toward the back end
    output logic                               o_q_valid,
    input  wire logic                          i_q_pop,
    output logic [SAMPLE_WIDTH-1:0]            o_q_value,
    output logic                               o_q_first,
    output logic [CW-1:0]                      o_len
);

    localparam int QD = swm_pkg::QUEUE_DEPTH;
    localparam int QA = swm_pkg::QUEUE_AW;

    logic [SAMPLE_WIDTH-1:0] r_q_value [QD];
    logic                    r_q_first [QD];
    logic [QA-1:0]           r_wptr, n_wptr;
    logic [QA-1:0]           r_rptr, n_rptr;
    logic [QA:0]             r_qcnt, n_qcnt;
    logic [CW-1:0]           r_len, n_len;
    logic                    push;
    logic                    pop;

    assign o_ready     = (r_qcnt != (QA+1)'(QD));
    assign o_cfg_ready = 1'b1;
    assign push        = i_valid && o_ready;
    assign pop         = i_q_pop && o_q_valid;

    assign o_q_valid = (r_qcnt != '0);
    assign o_q_value = r_q_value[r_rptr];
    assign o_q_first = r_q_first[r_rptr];
    assign o_len     = r_len;

    always_comb begin
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop ? r_rptr + 1'b1 : r_rptr;
        n_qcnt = r_qcnt;
        if (push && !pop) begin
            n_qcnt = r_qcnt + 1'b1;
        end else if (pop && !push) begin
            n_qcnt = r_qcnt - 1'b1;
        end
    end

    // Zero acts as one, anything above the store size acts as the store size.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_len = CW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            n_len = CW'(MAX_WINDOW);
        end else begin
            n_len = CW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_qcnt <= '0;
            r_len  <= CW'(1);
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_qcnt <= n_qcnt;
            if (i_cfg_valid) begin
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wptr] <= i_value;
            r_q_first[r_wptr] <= i_first;
        end
    end

endmodule

`default_nettype wire

@@ hdl/swm_back.sv @@
`default_nettype none

module swm_back #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32,
    parameter int CW           = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_valid,
    output logic                         o_q_pop,
    input  wire logic [SAMPLE_WIDTH-1:0] i_q_value,
    input  wire logic                    i_q_first,
    input  wire logic [CW-1:0]           i_len,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0]      o_value
);

    localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW       = $clog2(2 * MAX_WINDOW);
    localparam int POS_MOD  = 2 * MAX_WINDOW;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(MAX_WINDOW - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == '0) begin
            r = AW'(MAX_WINDOW - 1);
        end else begin
            r = a - 1'b1;
        end
        return r;
    endfunction

    // candidate store, one read port, registered read
    logic [SAMPLE_WIDTH-1:0] mem_val [MAX_WINDOW];
    logic [PW-1:0]           mem_pos [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_rd_val;
    logic [PW-1:0]           r_rd_pos;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;

    swm_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_filled, n_filled;
    logic [SAMPLE_WIDTH-1:0] r_val;
    logic            r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_data;
    logic            out_load;
    logic [PW:0]     age;
    logic            expired;

    // age of the candidate just read, positions wrap at twice the store size
    always_comb begin
        if (r_pos >= r_rd_pos) begin
            age = (PW+1)'(r_pos) - (PW+1)'(r_rd_pos);
        end else begin
            age = (PW+1)'(r_pos) + (PW+1)'(POS_MOD) - (PW+1)'(r_rd_pos);
        end
        expired = (age >= (PW+1)'(i_len));
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_pos    = r_pos;
        n_filled = r_filled;
        o_q_pop  = 1'b0;
        rd_addr  = r_head;
        wr_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = swm_pkg::S_EXP_RD;
                    if (i_q_first) begin
                        n_head   = '0;
                        n_tail   = '0;
                        n_count  = '0;
                        n_pos    = '0;
                        n_filled = '0;
                    end
                end
            end
            swm_pkg::S_EXP_RD: begin
                rd_addr = r_head;
                n_state = (r_count == '0) ? swm_pkg::S_DOM_RD : swm_pkg::S_EXP_CHK;
            end
            swm_pkg::S_EXP_CHK: begin
                if (expired) begin
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = swm_pkg::S_EXP_RD;
                end else begin
                    n_state = swm_pkg::S_DOM_RD;
                end
            end
            swm_pkg::S_DOM_RD: begin
                rd_addr = ptr_dec(r_tail);
                n_state = (r_count == '0) ? swm_pkg::S_PUSH : swm_pkg::S_DOM_CHK;
            end
            swm_pkg::S_DOM_CHK: begin
                // equal values: the newer sample takes over
                if ($signed(r_rd_val) <= $signed(r_val)) begin
                    n_tail  = ptr_dec(r_tail);
                    n_count = r_count - 1'b1;
                    n_state = swm_pkg::S_DOM_RD;
                end else begin
                    n_state = swm_pkg::S_PUSH;
                end
            end
            swm_pkg::S_PUSH: begin
                wr_en   = 1'b1;
                n_tail  = ptr_inc(r_tail);
                n_count = r_count + 1'b1;
                n_pos   = (r_pos == PW'(POS_MOD - 1)) ? '0 : r_pos + 1'b1;
                if (r_filled != CW'(MAX_WINDOW)) begin
                    n_filled = r_filled + 1'b1;
                end
                n_state = (n_filled >= i_len) ? swm_pkg::S_RES_RD : swm_pkg::S_IDLE;
            end
            swm_pkg::S_RES_RD: begin
                rd_addr = r_head;
                n_state = swm_pkg::S_RES;
            end
            swm_pkg::S_RES: begin
                rd_addr = r_head;
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_filled <= n_filled;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_val <= i_q_value;
        end
        if (out_load) begin
            r_out_data <= r_rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[r_tail] <= r_val;
            mem_pos[r_tail] <= r_pos;
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_pos <= mem_pos[rd_addr];
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_data;

endmodule

`default_nettype wire

@@ sim/swm_max_checker.sv @@
module swm_max_checker #(
    parameter int MAX_WINDOW   = 256,
    parameter int SAMPLE_WIDTH = 32,
    parameter int TDATA_W      = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic                        i_s_tready,
    // [SAMPLE_WIDTH-1:0] sample_value, upper bits zero padding
    input  wire logic [TDATA_W-1:0]          i_s_tdata,
    // [0] first_sample
    input  wire logic                        i_s_tuser,
    input  wire logic                        i_m_tvalid,
    input  wire logic                        i_m_tready,
    // [SAMPLE_WIDTH-1:0] window_max, upper bits zero padding
    input  wire logic [TDATA_W-1:0]          i_m_tdata,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int POS_SPAN = 2 * MAX_WINDOW;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic [31:0]             pos;
    } t_candidate;

    // monotonic store: positions rise and values strictly fall from front to back
    t_candidate                  candidates[$];
    logic [SAMPLE_WIDTH-1:0]     expected_max[$];
    int                          next_pos = 0;
    int                          filled = 0;
    logic [swm_pkg::CFG_W-1:0]   win_len = 1;
    int                          fails = 0;

    function automatic bit advance_window(input logic [SAMPLE_WIDTH-1:0] value,
                                          input bit first,
                                          output logic [SAMPLE_WIDTH-1:0] win_max);
        int         span;
        int         now;
        int         age;
        t_candidate c;
        span = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
        if (first) begin
            candidates.delete();
            next_pos = 0;
            filled   = 0;
        end
        now = next_pos;
        while (candidates.size() > 0) begin
            age = (now >= int'(candidates[0].pos)) ? now - int'(candidates[0].pos)
                                                   : now + POS_SPAN - int'(candidates[0].pos);
            if (age < span)
                break;
            void'(candidates.pop_front());
        end
        // equal values: the newer sample takes over
        while (candidates.size() > 0 && $signed(candidates[$].value) <= $signed(value))
            void'(candidates.pop_back());
        if (candidates.size() < MAX_WINDOW) begin
            c.value = value;
            c.pos   = now;
            candidates.push_back(c);
        end
        next_pos = (now + 1) % POS_SPAN;
        if (filled < MAX_WINDOW)
            filled++;
        win_max = candidates[0].value;
        return filled >= span;
    endfunction

    always @(posedge i_clk) begin : track
        logic [SAMPLE_WIDTH-1:0] want;
        logic [SAMPLE_WIDTH-1:0] win_max;
        if (!i_rst_n) begin
            candidates.delete();
            expected_max.delete();
            next_pos = 0;
            filled   = 0;
            win_len  = 1;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_max.size() == 0) begin
                    if (fails < 10)
                        $display("window max result with none expected: %0d",
                                 $signed(i_m_tdata[SAMPLE_WIDTH-1:0]));
                    fails++;
                end else begin
                    want = expected_max.pop_front();
                    if (i_m_tdata !== TDATA_W'(want)) begin
                        if (fails < 10)
                            $display("window max mismatch: expected %0d, got %0d",
                                     $signed(want), $signed(i_m_tdata[SAMPLE_WIDTH-1:0]));
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                win_len = i_cfg_data;
            if (i_s_tvalid && i_s_tready &&
                advance_window(i_s_tdata[SAMPLE_WIDTH-1:0], i_s_tuser, win_max))
                expected_max.push_back(win_max);
        end
        o_fail_count <= fails;
        o_pending    <= expected_max.size();
    end

endmodule

@@ sim/tb_sliding_window_max_top.sv @@
module tb_sliding_window_max_top;

    localparam int MAX_WINDOW    = 256;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 1150;
    // samples that give no result may still be in the queue or back end
    localparam int SETTLE_CYCLES = 1000;

    typedef enum {V_RANDOM, V_NARROW, V_FALL, V_RISE, V_EDGE} t_vmode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [TDATA_W-1:0]          s_tdata = '0;
    logic                        s_tuser = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [TDATA_W-1:0]          m_tdata;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [swm_pkg::CFG_W-1:0]   i_cfg_data = '0;

    int                          fail_count;
    int                          pending_count;

    bit                          steady = 1'b0;
    t_vmode                      vmode = V_RANDOM;
    int                          burst_left = 0;
    logic [SAMPLE_WIDTH-1:0]     ramp = '0;
    int                          calm_left = 0;
    int                          hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sliding_window_max_top #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    swm_max_checker #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TDATA_W      (TDATA_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // receiver: mostly short stalls, a few long ones, some calm stretches
    always @(posedge i_clk) begin
        int r;
        if (calm_left > 0) begin
            calm_left--;
            m_tready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 999);
            if (r < 5)
                calm_left = $urandom_range(50, 300);
            else if (r < 25)
                hold_left = $urandom_range(15, 60);
            else if (r < 300)
                hold_left = $urandom_range(0, 2);
            m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 8);
        if (r < 75)
            return $urandom_range(9, 40);
        if (r < 82)
            return 0;
        if (r < 88)
            return $urandom_range(41, 256);
        if (r < 95)
            return $urandom_range(257, 511);
        return 1;
    endfunction

    // values come in bursts of one shape; falling ramps give long candidate chains
    function automatic logic [SAMPLE_WIDTH-1:0] next_sample(input bit long_fall);
        if (burst_left == 0) begin
            if (long_fall && $urandom_range(0, 9) < 6) begin
                vmode      = V_FALL;
                burst_left = $urandom_range(100, 300);
            end else begin
                vmode      = t_vmode'($urandom_range(0, 4));
                burst_left = $urandom_range(4, 30);
            end
        end
        burst_left--;
        case (vmode)
            V_NARROW: ramp = SAMPLE_WIDTH'($urandom_range(0, 8) - 4);
            V_FALL:   ramp = ramp - SAMPLE_WIDTH'($urandom_range(0, 5));
            V_RISE:   ramp = ramp + SAMPLE_WIDTH'($urandom_range(0, 5));
            V_EDGE: begin
                case ($urandom_range(0, 5))
                    0:       ramp = 32'h8000_0000;
                    1:       ramp = 32'h7FFF_FFFF;
                    2:       ramp = 32'hFFFF_FFFF;
                    3:       ramp = 32'h0000_0000;
                    4:       ramp = 32'h0000_0001;
                    default: ramp = 32'h8000_0001;
                endcase
            end
            default:  ramp = $urandom();
        endcase
        return ramp;
    endfunction

    task automatic put_sample(input logic [SAMPLE_WIDTH-1:0] value, input bit first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        s_tuser  <= first;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input int len);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len[swm_pkg::CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n;
        int sent;
        bit first;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of one, stream counted from reset
        put_sample(32'h8000_0000, 1'b0);
        put_sample(32'h7FFF_FFFF, 1'b0);
        put_sample(32'hFFFF_FFFF, 1'b0);
        put_sample(32'h0000_0000, 1'b0);

        // zero length behaves as one
        set_window(0);
        put_sample(32'd5, 1'b1);

        // filling, equal values, expiry of the maximum
        set_window(3);
        put_sample(32'd10, 1'b1);
        put_sample(32'd10, 1'b0);
        put_sample(32'd7, 1'b0);
        put_sample(32'd7, 1'b0);
        put_sample(32'd7, 1'b0);
        put_sample(32'h7FFF_FFFF, 1'b0);
        put_sample(32'h8000_0000, 1'b0);
        put_sample(32'h8000_0000, 1'b0);
        put_sample(32'h8000_0000, 1'b0);

        // oversize length clamps to the store depth, changed mid-stream
        set_window(511);
        put_sample(32'hFFFF_FFFE, 1'b0);
        put_sample(32'h0000_0003, 1'b0);
        set_window(2);
        put_sample(32'h0000_0002, 1'b0);
        put_sample(32'd3, 1'b1);
        put_sample(32'd3, 1'b0);

        // full window over one long stream; positions wrap
        set_window(MAX_WINDOW);
        steady = 1'b0;
        for (int k = 0; k < 600; k++)
            put_sample(next_sample(1'b1), k == 0);
        sent = 600;

        while (sent < RANDOM_ITEMS) begin
            set_window(pick_window());
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            for (int k = 0; k < n; k++) begin
                first = (k == 0 && $urandom_range(0, 9) < 7) || ($urandom_range(0, 49) == 0);
                put_sample(next_sample(1'b0), first);
            end
            sent += n;
        end

        wait_idle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
